@@ rtl/irtr_pkg.sv @@
`default_nettype none

package irtr_pkg;

    localparam int CNT_W  = 24;
    localparam int DUR_W  = 16;
    localparam int TOT_W  = 11;
    localparam int MUL_W  = 17;
    localparam int UPT_W  = 8;
    localparam int GAP_W  = 16;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam int EDGE_LIMIT_DEF = 256;

    localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] TIMEOUT_RST     = 24'd2500000;
    localparam logic [GAP_W-1:0] END_GAP_RST     = 16'd1136;
    localparam logic [UPT_W-1:0] US_PER_TICK_RST = 8'd4;

    // Register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_TIMEOUT     = 2'd0;
    localparam logic [1:0] REG_END_GAP     = 2'd1;
    localparam logic [1:0] REG_US_PER_TICK = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_REC
    } t_phase;

    typedef enum logic [1:0] {
        ST_DURATION = 2'd0,
        ST_END      = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [CNT_W-1:0] timeout_ticks;
        logic [GAP_W-1:0] end_gap_ticks;
        logic [UPT_W-1:0] us_per_tick;
    } t_cfg;

    typedef struct packed {
        t_status          status;
        logic [DUR_W-1:0] duration_us;
        logic [TOT_W-1:0] edge_total;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/irtr_in_if.sv @@
`default_nettype none

interface irtr_in_if;
    logic valid;
    logic ready;
    logic command;
    logic ir_level;

    modport source (output valid, output command, output ir_level, input ready);
    modport sink   (input valid, input command, input ir_level, output ready);
endinterface

`default_nettype wire

@@ rtl/irtr_out_if.sv @@
`default_nettype none

interface irtr_out_if;
    logic                           valid;
    logic                           ready;
    irtr_pkg::t_status              status;
    logic [irtr_pkg::DUR_W-1:0]     duration_us;
    logic [irtr_pkg::TOT_W-1:0]     edge_total;
    logic                           last;

    modport source (output valid, output status, output duration_us, output edge_total,
                    output last, input ready);
    modport sink   (input valid, input status, input duration_us, input edge_total,
                    input last, output ready);
endinterface

`default_nettype wire

@@ rtl/irtr_cfg.sv @@
`default_nettype none

module irtr_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [irtr_pkg::APB_AW-1:0]   paddr,
    input  wire logic [irtr_pkg::APB_DW-1:0]   pwdata,
    output logic      [irtr_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output irtr_pkg::t_cfg                     o_cfg
);

    irtr_pkg::t_cfg r_cfg;
    irtr_pkg::t_cfg n_cfg;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (paddr[3:2])
                irtr_pkg::REG_TIMEOUT: begin
                    n_cfg.timeout_ticks = pwdata[irtr_pkg::CNT_W-1:0];
                end
                irtr_pkg::REG_END_GAP: begin
                    n_cfg.end_gap_ticks = pwdata[irtr_pkg::GAP_W-1:0];
                end
                irtr_pkg::REG_US_PER_TICK: begin
                    n_cfg.us_per_tick = pwdata[irtr_pkg::UPT_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks <= irtr_pkg::TIMEOUT_RST;
            r_cfg.end_gap_ticks <= irtr_pkg::END_GAP_RST;
            r_cfg.us_per_tick   <= irtr_pkg::US_PER_TICK_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[3:2])
            irtr_pkg::REG_TIMEOUT: begin
                prdata = irtr_pkg::APB_DW'(r_cfg.timeout_ticks);
            end
            irtr_pkg::REG_END_GAP: begin
                prdata = irtr_pkg::APB_DW'(r_cfg.end_gap_ticks);
            end
            irtr_pkg::REG_US_PER_TICK: begin
                prdata = irtr_pkg::APB_DW'(r_cfg.us_per_tick);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/irtr_core.sv @@
`default_nettype none

module irtr_core #(
    parameter int EDGE_LIMIT = irtr_pkg::EDGE_LIMIT_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  irtr_pkg::t_cfg      i_cfg,
    irtr_in_if.sink             i_in,
    irtr_out_if.source          o_out
);

    localparam int CNT_W  = irtr_pkg::CNT_W;
    localparam int DUR_W  = irtr_pkg::DUR_W;
    localparam int TOT_W  = irtr_pkg::TOT_W;
    localparam int MUL_W  = irtr_pkg::MUL_W;
    localparam int PROD_W = irtr_pkg::MUL_W + irtr_pkg::UPT_W;
    localparam int EDGE_W = $clog2(EDGE_LIMIT + 1);
    localparam logic [EDGE_W-1:0] EDGE_MAX = EDGE_W'(EDGE_LIMIT);

    // input register
    logic               r_in_valid;
    logic               r_in_cmd;
    logic               r_in_lvl;

    // recording state
    irtr_pkg::t_phase   r_phase;
    irtr_pkg::t_phase   n_phase;
    logic               r_prev;
    logic               n_prev;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [EDGE_W-1:0]  r_edges;
    logic [EDGE_W-1:0]  n_edges;

    // result register
    logic               r_out_valid;
    irtr_pkg::t_result  r_out;

    logic               w_adv;
    logic               w_consume;
    logic               w_edge;
    logic [CNT_W-1:0]   w_cnt_inc;
    logic [EDGE_W-1:0]  w_edges_inc;
    logic               w_full;
    logic               w_timeout;
    logic               w_gap;
    logic [MUL_W-1:0]   w_cnt_clamp;
    logic [PROD_W-1:0]  w_prod;
    logic [DUR_W-1:0]   w_dur;
    logic [TOT_W-1:0]   w_tot_inc;
    logic [TOT_W-1:0]   w_tot;
    logic               w_res_valid;
    irtr_pkg::t_result  w_res;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_consume  = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_consume;

    assign w_edge      = (r_in_lvl != r_prev);
    assign w_cnt_inc   = (r_cnt == irtr_pkg::CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign w_edges_inc = r_edges + 1'b1;
    assign w_full      = (w_edges_inc >= EDGE_MAX);
    assign w_timeout   = (w_cnt_inc >= i_cfg.timeout_ticks);
    assign w_gap       = (w_cnt_inc >= CNT_W'(i_cfg.end_gap_ticks));
    assign w_tot_inc   = TOT_W'(w_edges_inc);
    assign w_tot       = TOT_W'(r_edges);

    // Clamp to 2^16: any product from a count that large saturates unless the scale is zero
    assign w_cnt_clamp = (|w_cnt_inc[CNT_W-1:DUR_W]) ? MUL_W'(1 << DUR_W)
                                                     : MUL_W'(w_cnt_inc[DUR_W-1:0]);
    assign w_prod      = PROD_W'(w_cnt_clamp) * PROD_W'(i_cfg.us_per_tick);
    assign w_dur       = (|w_prod[PROD_W-1:DUR_W]) ? {DUR_W{1'b1}} : w_prod[DUR_W-1:0];

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (r_in_cmd) begin
            n_phase = irtr_pkg::PH_WAIT;
        end else begin
            case (r_phase)
                irtr_pkg::PH_WAIT: begin
                    if (w_edge) begin
                        n_phase = irtr_pkg::PH_REC;
                    end else if (w_timeout) begin
                        n_phase = irtr_pkg::PH_IDLE;
                    end
                end
                irtr_pkg::PH_REC: begin
                    if (w_edge ? w_full : w_gap) begin
                        n_phase = irtr_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // counters and result
    always_comb begin
        n_prev            = r_in_lvl;
        n_cnt             = r_cnt;
        n_edges           = r_edges;
        w_res_valid       = 1'b0;
        w_res.status      = irtr_pkg::ST_DURATION;
        w_res.duration_us = '0;
        w_res.edge_total  = w_tot;
        w_res.last        = 1'b1;
        if (r_in_cmd) begin
            n_prev  = 1'b1;
            n_cnt   = '0;
            n_edges = '0;
        end else begin
            case (r_phase)
                irtr_pkg::PH_WAIT: begin
                    if (w_edge) begin
                        n_cnt   = '0;
                        n_edges = EDGE_W'(1);
                    end else begin
                        n_cnt = w_cnt_inc;
                        if (w_timeout) begin
                            w_res_valid      = 1'b1;
                            w_res.status     = irtr_pkg::ST_TIMEOUT;
                            w_res.edge_total = '0;
                        end
                    end
                end
                irtr_pkg::PH_REC: begin
                    if (w_edge) begin
                        n_cnt            = '0;
                        n_edges          = w_edges_inc;
                        w_res_valid      = 1'b1;
                        w_res.edge_total = w_tot_inc;
                        if (w_full) begin
                            w_res.status = irtr_pkg::ST_FULL;
                        end else begin
                            w_res.duration_us = w_dur;
                            w_res.last        = 1'b0;
                        end
                    end else begin
                        n_cnt = w_cnt_inc;
                        if (w_gap) begin
                            w_res_valid  = 1'b1;
                            w_res.status = irtr_pkg::ST_END;
                        end
                    end
                end
                default: begin
                    n_cnt = r_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd <= i_in.command;
            r_in_lvl <= i_in.ir_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= irtr_pkg::PH_IDLE;
            r_prev  <= 1'b1;
            r_cnt   <= '0;
            r_edges <= '0;
        end else if (w_consume) begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_cnt   <= n_cnt;
            r_edges <= n_edges;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_consume && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out.status;
    assign o_out.duration_us = r_out.duration_us;
    assign o_out.edge_total  = r_out.edge_total;
    assign o_out.last        = r_out.last;

`ifndef SYNTH
    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && w_res_valid && w_res.last) |=> (r_phase == irtr_pkg::PH_IDLE))
        else $error("closing result did not return to idle");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_in_cmd) |=>
            (r_phase == irtr_pkg::PH_WAIT && r_cnt == '0 && r_edges == '0 && r_prev))
        else $error("start did not clear the recording state");

    a_quiet_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && (r_in_cmd || r_phase == irtr_pkg::PH_IDLE)) |-> !w_res_valid)
        else $error("result produced by start or idle tick");

    a_edges_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edges <= EDGE_MAX)
        else $error("edge count beyond limit");

    a_out_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

@@ rtl/ir_edge_timing_recorder.sv @@
// IR edge timing recorder.
// Input channel i_in: one transaction per timebase tick (command 0, ir_level
// carries the receiver sample) or a start (command 1). Output channel o_out:
// one transaction per result: duration, end of signal, timeout or too many
// edges, with last set on the result that closes a recording.
// Configuration: APB-style register port, timeout_ticks at 0x0,
// end_gap_ticks at 0x4, us_per_tick at 0x8; write only while idle.
// A result is computed from the input register and presented from the
// result register. Throughput: one input transaction per cycle while no
// result is stalled; the edge-to-edge duration is scaled by a single 17x8
// multiply between the two registers.
// Reset (i_rst_n low, synchronous): idle phase, level tracked as high,
// counters cleared, registers back to 2500000 / 1136 / 4.
// While a result waits with o_out.ready low the result register holds; at
// most one more transaction is absorbed by the input register, then
// i_in.ready drops until the result is taken.
`default_nettype none

module ir_edge_timing_recorder #(
    parameter int EDGE_LIMIT = irtr_pkg::EDGE_LIMIT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [irtr_pkg::APB_AW-1:0]   paddr,
    input  wire logic [irtr_pkg::APB_DW-1:0]   pwdata,
    output logic      [irtr_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    irtr_in_if.sink                            i_in,
    irtr_out_if.source                         o_out
);

    irtr_pkg::t_cfg w_cfg;

    irtr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    irtr_core #(
        .EDGE_LIMIT (EDGE_LIMIT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
